### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files that carry concurrent checks.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### rtl/core/omws_pkg.sv
// Package for the order-2 Markov word sampler: depths, widths, codes.
// Depends on nothing.
package omws_pkg;
  localparam int OUTER_DEPTH  = 256;
  localparam int MIDDLE_DEPTH = 1024;
  localparam int LEAF_DEPTH   = 4096;
  localparam int OUTER_AW  = $clog2(OUTER_DEPTH) > 0 ? $clog2(OUTER_DEPTH) : 1;
  localparam int MIDDLE_AW = $clog2(MIDDLE_DEPTH) > 0 ? $clog2(MIDDLE_DEPTH) : 1;
  localparam int LEAF_AW   = $clog2(LEAF_DEPTH) > 0 ? $clog2(LEAF_DEPTH) : 1;
  localparam int CP_W = 21;
  localparam int RANGE_W = 21 + 12 + 13;
  localparam int LEAF_W  = 21 + 32;

  typedef enum logic [2:0] {
    ACT_WR_OUTER  = 3'd0,
    ACT_WR_MIDDLE = 3'd1,
    ACT_WR_LEAF   = 3'd2,
    ACT_DRAW      = 3'd3,
    ACT_RESTART   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_CTX   = 2'd1,
    ST_NO_WEIGHT = 2'd2
  } status_t;

  localparam logic REG_OUTER_USED = 1'b0;
  localparam logic REG_MAX_LEN    = 1'b1;
endpackage

### rtl/core/omws_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
module omws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/order2_markov_word_sampler.sv
// Order-2 Markov word sampler. A draw searches the outer range (about log2 of
// outer_entries_used+1 RAM reads), then the middle range likewise, reduces
// random_word by the middle sum with a bit-serial restoring divider, then walks
// the leaf range one entry per RAM read. A failed lookup or a walk that runs
// out also ends in a result. One item is worked at a time; in_ready is low
// while a draw is in flight or its result waits in the output register.
// Channels: in_valid/in_ready carries an action with its fields; out_valid/
// out_ready carries one result per draw. Other actions give no result.
// cfg_we/cfg_index/cfg_data writes outer_entries_used (0), max_word_length (1).
// Reset (rst, synchronous) clears history and the character count, sets
// outer_entries_used to 0, max_word_length to 16; tables are undefined until
// written. While the receiver stalls, the result is held and nothing is taken.
// Depends on omws_pkg, omws_ram and assert_macros.svh.
`include "assert_macros.svh"
module order2_markov_word_sampler import omws_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [11:0] entry_index,
  input  logic [20:0] key_codepoint,
  input  logic [11:0] child_start,
  input  logic [12:0] child_count,
  input  logic [31:0] weight,
  input  logic [63:0] random_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] next_codepoint,
  output logic        is_character,
  output logic        last,
  output logic [1:0]  status,
  output logic [15:0] word_length
);
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_OREQ = 9'b000000010,
    S_ORD  = 9'b000000100,
    S_MREQ = 9'b000001000,
    S_MRD  = 9'b000010000,
    S_DIV  = 9'b000100000,
    S_LREQ = 9'b001000000,
    S_LRD  = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t state;
  logic [8:0]  outer_used;
  logic [15:0] max_len;
  logic [20:0] hist_old, hist_new;
  logic [15:0] chars;
  logic [63:0] rnd;
  logic [31:0] sum;
  logic [13:0] lo, hi;      // search bounds, relative
  logic [13:0] base;        // absolute base of middle range / leaf index
  logic [12:0] leaf_left;
  logic [11:0] leaf_start;
  logic [32:0] rem;
  logic [6:0]  div_cnt;
  logic        fail_ctx;
  logic [20:0] cp_pick;
  logic        picked;

  // memories
  logic                o_we, m_we, l_we;
  logic [OUTER_AW-1:0] o_raddr;
  logic [MIDDLE_AW-1:0] m_raddr;
  logic [LEAF_AW-1:0]  l_raddr;
  logic [RANGE_W-1:0]  o_rdata, m_rdata;
  logic [31:0]         s_rdata;
  logic [LEAF_W-1:0]   l_rdata;

  wire in_xfer = in_valid && in_ready;
  assign in_ready = (state == S_IDLE) && !out_valid;
  assign o_we = in_xfer && action == ACT_WR_OUTER  && entry_index < 12'(OUTER_DEPTH);
  assign m_we = in_xfer && action == ACT_WR_MIDDLE && entry_index < 12'(MIDDLE_DEPTH);
  assign l_we = in_xfer && action == ACT_WR_LEAF   && 13'(entry_index) < 13'(LEAF_DEPTH);

  wire [13:0] mid = lo + ((hi - lo) >> 1);
  wire [13:0] mabs = base + mid;
  assign o_raddr = mid[OUTER_AW-1:0];
  assign m_raddr = mabs[MIDDLE_AW-1:0];
  assign l_raddr = base[LEAF_AW-1:0];

  omws_ram #(.WIDTH(RANGE_W), .DEPTH(OUTER_DEPTH)) u_outer (
    .clk, .we(o_we), .waddr(entry_index[OUTER_AW-1:0]),
    .wdata({key_codepoint, child_start, child_count}), .raddr(o_raddr), .rdata(o_rdata));
  omws_ram #(.WIDTH(RANGE_W), .DEPTH(MIDDLE_DEPTH)) u_middle (
    .clk, .we(m_we), .waddr(entry_index[MIDDLE_AW-1:0]),
    .wdata({key_codepoint, child_start, child_count}), .raddr(m_raddr), .rdata(m_rdata));
  omws_ram #(.WIDTH(32), .DEPTH(MIDDLE_DEPTH)) u_sums (
    .clk, .we(m_we), .waddr(entry_index[MIDDLE_AW-1:0]),
    .wdata(weight), .raddr(m_raddr), .rdata(s_rdata));
  omws_ram #(.WIDTH(LEAF_W), .DEPTH(LEAF_DEPTH)) u_leaf (
    .clk, .we(l_we), .waddr(entry_index[LEAF_AW-1:0]),
    .wdata({key_codepoint, weight}), .raddr(l_raddr), .rdata(l_rdata));

  wire [20:0] o_key = o_rdata[45:25];
  wire [11:0] o_st  = o_rdata[24:13];
  wire [12:0] o_cn  = o_rdata[12:0];
  wire [20:0] m_key = m_rdata[45:25];
  wire [11:0] m_st  = m_rdata[24:13];
  wire [12:0] m_cn  = m_rdata[12:0];
  wire [20:0] l_cp  = l_rdata[52:32];
  wire [31:0] l_fr  = l_rdata[31:0];

  // clipped child range lengths
  wire [13:0] m_room = 14'(MIDDLE_DEPTH) - 14'(o_st);
  wire [13:0] mn = (14'(o_st) >= 14'(MIDDLE_DEPTH)) ? 14'd0 :
                   ((14'(o_cn) > m_room) ? m_room : 14'(o_cn));
  wire [13:0] l_room = 14'(LEAF_DEPTH) - 14'(m_st);
  wire [13:0] ln = (14'(m_st) >= 14'(LEAF_DEPTH)) ? 14'd0 :
                   ((14'(m_cn) > l_room) ? l_room : 14'(m_cn));

  wire [32:0] rem_sh = {rem[31:0], rnd[63]};
  wire        rem_ge = rem_sh >= {1'b0, sum};
  wire [15:0] chars_inc = (cp_pick != '0 && chars != 16'hFFFF) ? chars + 16'd1 : chars;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      outer_used <= '0;
      max_len <= 16'd16;
      hist_old <= '0;
      hist_new <= '0;
      chars <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_OUTER_USED) outer_used <= cfg_data[8:0];
        else max_len <= cfg_data;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (action == ACT_RESTART) begin
              hist_old <= '0;
              hist_new <= '0;
              chars <= '0;
            end else if (action == ACT_DRAW) begin
              rnd <= random_word;
              lo <= '0;
              hi <= (outer_used > 9'(OUTER_DEPTH)) ? 14'(OUTER_DEPTH) : 14'(outer_used);
              base <= '0;
              picked <= 1'b0;
              state <= S_OREQ;
            end
          end
        end
        S_OREQ: begin
          if (lo < hi) state <= S_ORD;
          else begin
            fail_ctx <= 1'b1;
            state <= S_FIN;
          end
        end
        S_ORD: begin
          if (hist_old == o_key) begin
            base <= 14'(o_st);
            lo <= '0;
            hi <= mn;
            state <= S_MREQ;
          end else begin
            if (hist_old < o_key) hi <= mid; else lo <= mid + 14'd1;
            state <= S_OREQ;
          end
        end
        S_MREQ: begin
          if (lo < hi) state <= S_MRD;
          else begin
            fail_ctx <= 1'b1;
            state <= S_FIN;
          end
        end
        S_MRD: begin
          if (hist_new == m_key) begin
            sum <= s_rdata;
            leaf_start <= m_st;
            leaf_left <= 13'(ln);
            rem <= '0;
            div_cnt <= '0;
            fail_ctx <= 1'b0;
            if (s_rdata == '0) state <= S_FIN;
            else state <= S_DIV;
          end else begin
            if (hist_new < m_key) hi <= mid; else lo <= mid + 14'd1;
            state <= S_MREQ;
          end
        end
        S_DIV: begin
          // restoring remainder, one bit per cycle
          rem <= rem_ge ? rem_sh - {1'b0, sum} : rem_sh;
          rnd <= {rnd[62:0], 1'b0};
          div_cnt <= div_cnt + 7'd1;
          if (div_cnt == 7'd63) begin
            base <= 14'(leaf_start);
            state <= S_LREQ;
          end
        end
        S_LREQ: begin
          if (leaf_left != '0) state <= S_LRD;
          else state <= S_FIN;
        end
        S_LRD: begin
          if (rem[31:0] < l_fr) begin
            cp_pick <= l_cp;
            picked <= 1'b1;
            state <= S_FIN;
          end else begin
            rem <= {1'b0, rem[31:0] - l_fr};
            base <= base + 14'd1;
            leaf_left <= leaf_left - 13'd1;
            state <= S_LREQ;
          end
        end
        S_FIN: begin
          out_valid <= 1'b1;
          if (!picked) begin
            next_codepoint <= '0;
            is_character <= 1'b0;
            last <= 1'b1;
            status <= fail_ctx ? ST_NO_CTX : ST_NO_WEIGHT;
            word_length <= chars;
            hist_old <= '0;
            hist_new <= '0;
            chars <= '0;
          end else begin
            next_codepoint <= cp_pick;
            is_character <= cp_pick != '0;
            status <= ST_OK;
            word_length <= chars_inc;
            if (cp_pick == '0 || chars_inc >= max_len) begin
              last <= 1'b1;
              hist_old <= '0;
              hist_new <= '0;
              chars <= '0;
            end else begin
              last <= 1'b0;
              hist_old <= hist_new;
              hist_new <= cp_pick;
              chars <= chars_inc;
            end
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_no_accept_busy, clk, rst, state != S_IDLE, !in_ready, "accept while busy")
  `ASSERT_NEXT(a_fin_result, clk, rst, state == S_FIN, out_valid, "draw gave no result")
  `ASSERT_IMPL(a_err_ends, clk, rst, out_valid && status != ST_OK, last && !is_character,
               "error result must end word")
endmodule

### test/tb_order2_markov_word_sampler.sv
// Testbench for order2_markov_word_sampler: loads the transition tables, walks a
// table of directed items, then random items under several settings and idling
// phases; draws are checked against a predictor or a typed row. Needs omws_pkg.
module tb_order2_markov_word_sampler import omws_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 60000;
  localparam int ITEMS_PER_PHASE = 60;

  typedef struct packed {
    logic [20:0] cp;
    logic        is_char;
    logic        ends;
    status_t     st;
    logic [15:0] len;
  } draw_result_t;

  typedef struct {
    bit           is_cfg;
    logic [2:0]   act;
    logic [11:0]  idx;
    logic [20:0]  key;
    logic [11:0]  cs;
    logic [12:0]  cc;
    logic [31:0]  wt;
    logic [63:0]  rnd;
    bit           typed;
    draw_result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  action = '0;
  logic [11:0] entry_index = '0;
  logic [20:0] key_codepoint = '0;
  logic [11:0] child_start = '0;
  logic [12:0] child_count = '0;
  logic [31:0] weight = '0;
  logic [63:0] random_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [20:0] next_codepoint;
  logic        is_character;
  logic        last;
  logic [1:0]  status;
  logic [15:0] word_length;

  // typed expectation travels with the payload
  bit           row_typed = 1'b0;
  draw_result_t row_res = '0;

  order2_markov_word_sampler u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .entry_index(entry_index), .key_codepoint(key_codepoint),
    .child_start(child_start), .child_count(child_count), .weight(weight),
    .random_word(random_word), .out_valid(out_valid), .out_ready(out_ready),
    .next_codepoint(next_codepoint), .is_character(is_character), .last(last),
    .status(status), .word_length(word_length)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [20:0] ot_key [OUTER_DEPTH];
  logic [11:0] ot_start [OUTER_DEPTH];
  logic [12:0] ot_count [OUTER_DEPTH];
  logic [20:0] mt_key [MIDDLE_DEPTH];
  logic [11:0] mt_start [MIDDLE_DEPTH];
  logic [12:0] mt_count [MIDDLE_DEPTH];
  logic [31:0] mt_sum [MIDDLE_DEPTH];
  logic [20:0] lf_cp [LEAF_DEPTH];
  logic [31:0] lf_freq [LEAF_DEPTH];
  logic [20:0] hist_old = '0;
  logic [20:0] hist_new = '0;
  logic [15:0] char_count = '0;
  logic [8:0]  outer_used = '0;
  logic [15:0] max_len = 16'd16;

  draw_result_t pending_draws[$];
  int errors = 0;
  int tx_pct = 0;
  int rx_pct = 0;
  int idle_cycles = 0;
  logic [20:0] alph [16];

  function automatic int clip(int start, int count, int depth);
    if (start >= depth) return 0;
    if (count > depth - start) return depth - start;
    return count;
  endfunction

  function automatic int find_key(bit in_middle, int base, int n, logic [20:0] k);
    int lo, hi, mid;
    logic [20:0] e;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      e = in_middle ? mt_key[base + mid] : ot_key[base + mid];
      if (k == e) return base + mid;
      if (k < e) hi = mid;
      else lo = mid + 1;
    end
    return -1;
  endfunction

  function automatic void clear_word();
    hist_old = '0;
    hist_new = '0;
    char_count = '0;
  endfunction

  function automatic void predict_item(logic [2:0] act, logic [11:0] idx, logic [20:0] key,
                                       logic [11:0] cs, logic [12:0] cc, logic [31:0] wt,
                                       logic [63:0] rnd, bit typed, draw_result_t tres);
    draw_result_t r;
    int n_outer, oi, mi, ms, mn, ls, ln;
    logic [63:0] choice;
    logic [20:0] cp;
    bit chosen;
    status_t st;
    case (action_t'(act))
      ACT_WR_OUTER: if (idx < OUTER_DEPTH) begin
        ot_key[idx] = key; ot_start[idx] = cs; ot_count[idx] = cc;
      end
      ACT_WR_MIDDLE: if (idx < MIDDLE_DEPTH) begin
        mt_key[idx] = key; mt_start[idx] = cs; mt_count[idx] = cc; mt_sum[idx] = wt;
      end
      ACT_WR_LEAF: if (idx < LEAF_DEPTH) begin
        lf_cp[idx] = key; lf_freq[idx] = wt;
      end
      ACT_RESTART: clear_word();
      ACT_DRAW: begin
        chosen = 1'b0;
        cp = '0;
        st = ST_OK;
        n_outer = (outer_used > OUTER_DEPTH) ? OUTER_DEPTH : int'(outer_used);
        oi = find_key(1'b0, 0, n_outer, hist_old);
        if (oi < 0) st = ST_NO_CTX;
        else begin
          ms = int'(ot_start[oi]);
          mn = clip(ms, int'(ot_count[oi]), MIDDLE_DEPTH);
          mi = find_key(1'b1, ms, mn, hist_new);
          if (mi < 0) st = ST_NO_CTX;
          else if (mt_sum[mi] == 0) st = ST_NO_WEIGHT;
          else begin
            choice = rnd % {32'd0, mt_sum[mi]};
            ls = int'(mt_start[mi]);
            ln = clip(ls, int'(mt_count[mi]), LEAF_DEPTH);
            for (int i = 0; i < ln && !chosen; i++) begin
              if (choice < {32'd0, lf_freq[ls + i]}) begin
                cp = lf_cp[ls + i];
                chosen = 1'b1;
              end else choice -= {32'd0, lf_freq[ls + i]};
            end
            if (!chosen) st = ST_NO_WEIGHT;
          end
        end
        if (!chosen) begin
          r = '{cp: '0, is_char: 1'b0, ends: 1'b1, st: st, len: char_count};
          clear_word();
        end else begin
          if (cp != 0 && char_count != 16'hFFFF) char_count++;
          hist_old = hist_new;
          hist_new = cp;
          r = '{cp: cp, is_char: cp != 0, ends: (cp == 0) || (char_count >= max_len),
                st: ST_OK, len: char_count};
          if (r.ends) clear_word();
        end
        pending_draws.push_back(typed ? tres : r);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
    errors++;
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, exp_val, $realtime);
  endtask

  always @(posedge clk) begin
    draw_result_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_draws.size() == 0) report_mismatch("result with nothing pending", 0, 0);
        else begin
          e = pending_draws.pop_front();
          if (next_codepoint !== e.cp) report_mismatch("next_codepoint", next_codepoint, e.cp);
          if (is_character !== e.is_char) report_mismatch("is_character", is_character, e.is_char);
          if (last !== e.ends) report_mismatch("last", last, e.ends);
          if (status !== e.st) report_mismatch("status", status, e.st);
          if (word_length !== e.len) report_mismatch("word_length", word_length, e.len);
        end
      end
      if (in_valid && in_ready)
        predict_item(action, entry_index, key_codepoint, child_start, child_count, weight,
                     random_word, row_typed, row_res);
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= rx_pct);

  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("order2_markov_word_sampler regression: fail");
      $finish;
    end
  end

  task automatic send_item(stim_row_t r, int gap_pct);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    action <= r.act;
    entry_index <= r.idx;
    key_codepoint <= r.key;
    child_start <= r.cs;
    child_count <= r.cc;
    weight <= r.wt;
    random_word <= r.rnd;
    row_typed <= r.typed;
    row_res <= r.res;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_draws.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reg(logic idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_OUTER_USED) outer_used = val[8:0];
    else max_len = val;
    @(posedge clk);
  endtask

  function automatic stim_row_t mk_item(action_t act, int idx, int key, int cs, int cc,
                                        logic [31:0] wt, logic [63:0] rnd,
                                        bit typed = 1'b0, status_t st = ST_OK);
    stim_row_t r;
    r = '{is_cfg: 1'b0, act: act, idx: 12'(idx), key: 21'(key), cs: 12'(cs), cc: 13'(cc),
          wt: wt, rnd: rnd, typed: typed,
          res: '{cp: '0, is_char: 1'b0, ends: 1'b1, st: st, len: '0}};
    return r;
  endfunction

  function automatic stim_row_t mk_cfg(logic idx, logic [15:0] val);
    stim_row_t r;
    r = mk_item(ACT_RESTART, 0, 0, 0, 0, '0, '0);
    r.is_cfg = 1'b1;
    r.idx = 12'(idx);
    r.wt = 32'(val);
    return r;
  endfunction

  // sparse tables: 16 outer contexts of 4 middle keys each, 2 leaves per middle,
  // middles 1020..1023 for the clipped range, and the outer slots 16, 32, 64
  // and 128 that a binary search over more than 16 entries passes through
  task automatic load_tables();
    logic [31:0] f, total;
    for (int m = 0; m < 64; m++) begin
      total = 0;
      for (int j = 0; j < 2; j++) begin
        f = $urandom_range(15);
        total += f;
        send_item(mk_item(ACT_WR_LEAF, 2 * m + j, int'(alph[$urandom_range(15)]), 0, 0, f,
                          '0), 0);
      end
      // an oversized sum now and then leaves the walk short
      if ($urandom_range(7) == 0) total += $urandom_range(1, 3);
      send_item(mk_item(ACT_WR_MIDDLE, m, int'(alph[5 * (m % 4)]), 2 * m, 2, total, '0), 0);
    end
    for (int m = 1020; m < 1024; m++)
      send_item(mk_item(ACT_WR_MIDDLE, m, int'(alph[m - 1008]), 0, 2, 32'd8, '0), 0);
    for (int o = 0; o < 16; o++)
      send_item(mk_item(ACT_WR_OUTER, o, int'(alph[o]), 4 * o, 4, '0, '0), 0);
    for (int o = 16; o < OUTER_DEPTH; o = 2 * o)
      send_item(mk_item(ACT_WR_OUTER, o, int'(alph[15]), 60, 4, '0, '0), 0);
  endtask

  task automatic make_random(output stim_row_t r);
    int pick, m;
    pick = $urandom_range(99);
    r = mk_item(ACT_DRAW, $urandom_range(4095), $urandom_range(1114111), $urandom_range(4095),
                $urandom_range(4096), $urandom, {$urandom, $urandom});
    if (pick < 70) r.act = ACT_DRAW;
    else if (pick < 78) r.act = ACT_RESTART;
    else if (pick < 86) begin
      r.act = ACT_WR_LEAF;
      r.key = alph[$urandom_range(15)];
      r.wt = ($urandom_range(9) == 0) ? $urandom : $urandom_range(15);
    end else if (pick < 90) begin
      m = $urandom_range(63);
      r.act = ACT_WR_MIDDLE;
      r.idx = 12'(m);
      r.key = alph[5 * (m % 4)];
      r.cs = 12'(2 * m);
      r.cc = 13'd2;
      r.wt = $urandom_range(40);
    end else if (pick < 92) begin
      r.act = ACT_WR_OUTER;
      r.idx = 12'($urandom_range(256, 4095));
    end else if (pick < 94) begin
      r.act = ACT_WR_MIDDLE;
      r.idx = 12'($urandom_range(256, 4095));
    end else if (pick < 97) r.act = 3'($urandom_range(5, 7));
    else r.act = ACT_WR_LEAF;
  endtask

  initial begin
    stim_row_t rows[$];
    stim_row_t r;
    int ph_used[8] = '{16, 256, 511, 16, 0, 16, 128, 16};
    int ph_len[8] = '{16, 3, 65535, 1, 5, 0, 7, 16};
    alph[0] = 21'h0;
    for (int k = 1; k < 14; k++) alph[k] = 21'h60 + 21'(k);
    alph[14] = 21'h0FFFF;
    alph[15] = 21'h10FFFF;

    rows.push_back(mk_item(ACT_DRAW, 0, 0, 0, 0, '0, '0, 1'b1, ST_NO_CTX));
    rows.push_back(mk_item(action_t'(3'd5), 4095, 1114111, 4095, 4096, '1, '1));
    rows.push_back(mk_item(action_t'(3'd6), 0, 0, 0, 0, '0, '0));
    rows.push_back(mk_item(action_t'(3'd7), 4095, 1114111, 4095, 4096, '1, '1));
    rows.push_back(mk_cfg(REG_OUTER_USED, 16));
    rows.push_back(mk_cfg(REG_MAX_LEN, 0));
    rows.push_back(mk_item(ACT_DRAW, 4095, 1114111, 4095, 4096, '1, '1));
    rows.push_back(mk_item(ACT_DRAW, 0, 0, 0, 0, '0, '0));
    rows.push_back(mk_item(ACT_WR_OUTER, 4095, 1114111, 4095, 4096, '1, '1));
    rows.push_back(mk_item(ACT_WR_MIDDLE, 1024, 1114111, 4095, 4096, '1, '1));
    rows.push_back(mk_item(ACT_WR_LEAF, 4095, 1114111, 4095, 4096, '1, '1));
    rows.push_back(mk_item(ACT_WR_MIDDLE, 0, 0, 0, 4, 32'd0, '0));
    rows.push_back(mk_item(ACT_DRAW, 0, 0, 0, 0, '0, '1, 1'b1, ST_NO_WEIGHT));
    rows.push_back(mk_item(ACT_WR_MIDDLE, 0, 0, 0, 4, 32'hFFFF_FFFF, '0));
    rows.push_back(mk_item(ACT_DRAW, 0, 0, 0, 0, '0, 64'hFFFF_FFFE, 1'b1, ST_NO_WEIGHT));
    rows.push_back(mk_item(ACT_WR_OUTER, 0, 0, 0, 0, '0, '0));
    rows.push_back(mk_item(ACT_DRAW, 0, 0, 0, 0, '0, 64'd5, 1'b1, ST_NO_CTX));
    rows.push_back(mk_item(ACT_WR_OUTER, 0, 0, 1020, 4096, '0, '0));
    rows.push_back(mk_item(ACT_DRAW, 0, 0, 0, 0, '0, 64'd9));
    rows.push_back(mk_item(ACT_WR_OUTER, 0, 0, 0, 4, '0, '0));
    rows.push_back(mk_item(ACT_WR_LEAF, 4094, 21'h63, 0, 0, 32'd30, '0));
    rows.push_back(mk_item(ACT_WR_MIDDLE, 0, 0, 4094, 4096, 32'd100, '0));
    rows.push_back(mk_item(ACT_DRAW, 0, 0, 0, 0, '0, 64'd42));
    rows.push_back(mk_item(ACT_RESTART, 0, 0, 0, 0, '0, '0));
    rows.push_back(mk_cfg(REG_MAX_LEN, 16'hFFFF));
    rows.push_back(mk_cfg(REG_OUTER_USED, 511));
    rows.push_back(mk_item(ACT_DRAW, 0, 0, 0, 0, '0, '1));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    load_tables();
    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        wait_idle();
        set_reg(rows[i].idx[0], rows[i].wt[15:0]);
      end else send_item(rows[i], 0);
    end
    wait_idle();
    load_tables();

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      tx_pct = 0;
      rx_pct = 0;
      set_reg(REG_OUTER_USED, 16'(ph_used[p]));
      set_reg(REG_MAX_LEN, 16'(ph_len[p]));
      case (p % 4)
        1: tx_pct = 46;
        2: rx_pct = 46;
        3: begin tx_pct = 17; rx_pct = 17; end
        default: ;
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        make_random(r);
        send_item(r, tx_pct);
      end
    end
    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("order2_markov_word_sampler regression: pass");
    else $display("order2_markov_word_sampler regression: fail");
    $finish;
  end
endmodule
